// ----- design/tspbb_pkg.sv -----
// ---------------------------------------------------------------------------
// tspbb_pkg
// Shared constants, state encoding and control structs for the tour search.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package tspbb_pkg;
	localparam int CITIES    = 8;
	localparam int DIST_BITS = 16;
	localparam int CITY_W    = 3;
	localparam int DEPTH_W   = 4;
	localparam int COST_W    = 20;
	localparam int BND_W     = 21;
	localparam int SUM_W     = 19;
	localparam int ADDR_W    = 2 * CITY_W;
	localparam int STORE_DEPTH = 1 << ADDR_W;

	localparam logic [COST_W-1:0]    COST_MAX = {COST_W{1'b1}};
	localparam logic [DIST_BITS-1:0] DIST_MAX = {DIST_BITS{1'b1}};
	localparam logic [CITY_W-1:0]    LAST_CITY = CITY_W'(CITIES - 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MIN_RD,
		ST_MIN_ACC,
		ST_INIT,
		ST_STEP,
		ST_EXT,
		ST_CLOSE,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic wr;
		logic min_start;
		logic min_rd;
		logic min_acc;
		logic init;
		logic step;
		logic ext;
		logic close;
		logic up;
		logic out_adv;
	} cmd_t;

	typedef struct packed {
		logic min_last;
		logic d_full;
		logic exhausted;
		logic visited;
		logic last_up;
		logic out_last;
	} status_t;
endpackage

// ----- design/tspbb_ctrl.sv -----
// ---------------------------------------------------------------------------
// tspbb_ctrl
// Sequencer for matrix load, row minimum sweep, depth-first search and
// result readout.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tspbb_ctrl import tspbb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    item_valid,
	input  logic    kind,
	input  logic    result_stall,
	input  status_t status,
	output cmd_t    cmd,
	output logic    busy,
	output logic    result_valid
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		busy         = (state_q != ST_IDLE);
		result_valid = (state_q == ST_OUT);
		unique case (state_q)
			ST_IDLE: begin
				if (item_valid) begin
					if (kind) begin
						cmd.min_start = 1'b1;
						state_d       = ST_MIN_RD;
					end else begin
						cmd.wr = 1'b1;
					end
				end
			end
			ST_MIN_RD: begin
				cmd.min_rd = 1'b1;
				state_d    = ST_MIN_ACC;
			end
			ST_MIN_ACC: begin
				cmd.min_acc = 1'b1;
				state_d     = status.min_last ? ST_INIT : ST_MIN_RD;
			end
			ST_INIT: begin
				cmd.init = 1'b1;
				state_d  = ST_STEP;
			end
			ST_STEP: begin
				if (status.d_full) begin
					state_d = ST_CLOSE;
				end else if (status.exhausted) begin
					cmd.up  = 1'b1;
					state_d = status.last_up ? ST_OUT : ST_STEP;
				end else begin
					cmd.step = 1'b1;
					if (!status.visited) state_d = ST_EXT;
				end
			end
			ST_EXT: begin
				cmd.ext = 1'b1;
				state_d = ST_STEP;
			end
			ST_CLOSE: begin
				cmd.close = 1'b1;
				cmd.up    = 1'b1;
				state_d   = status.last_up ? ST_OUT : ST_STEP;
			end
			ST_OUT: begin
				if (!result_stall) begin
					cmd.out_adv = 1'b1;
					if (status.out_last) state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end
endmodule

// ----- design/tspbb_dp.sv -----
// ---------------------------------------------------------------------------
// tspbb_dp
// Distance memory, row minima, per-level search stack and best tour.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tspbb_dp import tspbb_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmd_t                  cmd,
	input  logic [CITY_W-1:0]     row,
	input  logic [CITY_W-1:0]     col,
	input  logic [DIST_BITS-1:0]  distance,
	output status_t               status,
	output logic [CITY_W-1:0]     position,
	output logic [CITY_W-1:0]     city,
	output logic [COST_W-1:0]     tour_cost,
	output logic                  last
);
	logic [DIST_BITS-1:0] mem [STORE_DEPTH];
	logic [DIST_BITS-1:0] rd_q;
	logic [ADDR_W-1:0]    rd_addr;

	logic [CITY_W-1:0]    r_q, j_q;
	logic [DIST_BITS-1:0] m_q;
	logic [SUM_W-1:0]     sum_q;
	logic [DIST_BITS-1:0] rowmin_q [CITIES];

	logic [CITIES-1:0]        vis_q;
	logic [CITY_W-1:0]        path_q  [CITIES];
	logic [COST_W-1:0]        cost_q  [CITIES];
	logic signed [BND_W-1:0]  bnd_q   [CITIES];
	logic [DEPTH_W-1:0]       try_q   [CITIES];
	logic [DEPTH_W-1:0]       d_q;
	logic [COST_W-1:0]        best_q;
	logic [CITY_W-1:0]        bpath_q [CITIES];
	logic [CITY_W-1:0]        ocnt_q;

	logic [CITY_W-1:0]        dcur, dm1, prev, ic;
	logic [DEPTH_W-1:0]       itry, dnext;
	logic [DIST_BITS-1:0]     mm;
	logic [COST_W-1:0]        nc;
	logic signed [BND_W-1:0]  nb;
	logic signed [BND_W:0]    lhs;
	logic                     keep, better;

	assign dcur  = d_q[CITY_W-1:0];
	assign dm1   = CITY_W'(d_q - DEPTH_W'(1));
	assign dnext = d_q + DEPTH_W'(1);
	assign prev  = path_q[dm1];
	assign itry  = try_q[dcur];
	assign ic    = itry[CITY_W-1:0];

	assign status.min_last  = (r_q == LAST_CITY) && (j_q == LAST_CITY);
	assign status.d_full    = (d_q >= DEPTH_W'(CITIES));
	assign status.exhausted = (itry >= DEPTH_W'(CITIES));
	assign status.visited   = vis_q[ic];
	assign status.last_up   = (d_q == DEPTH_W'(1));
	assign status.out_last  = (ocnt_q == LAST_CITY);

	assign rd_addr = cmd.min_rd ? {r_q, j_q}
	               : (status.d_full ? {prev, path_q[0]} : {prev, ic});

	assign mm = ((j_q != r_q) && (rd_q < m_q)) ? rd_q : m_q;

	// bound may go negative; compare in one extra bit
	assign nc     = cost_q[dm1] + COST_W'(rd_q);
	assign nb     = bnd_q[dm1] - $signed({{(BND_W-DIST_BITS){1'b0}}, rowmin_q[prev]});
	assign lhs    = $signed({1'b0, nc}) + {nb[BND_W-1], nb};
	assign keep   = lhs < $signed({1'b0, best_q});
	assign better = nc < best_q;

	always_ff @(posedge clk) begin
		if (cmd.wr) mem[{row, col}] <= distance;
		rd_q <= mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (cmd.min_start) begin
			r_q   <= '0;
			j_q   <= '0;
			m_q   <= DIST_MAX;
			sum_q <= '0;
		end else if (cmd.min_acc) begin
			if (j_q == LAST_CITY) begin
				rowmin_q[r_q] <= mm;
				sum_q <= sum_q + SUM_W'(mm);
				m_q   <= DIST_MAX;
				j_q   <= '0;
				r_q   <= r_q + CITY_W'(1);
			end else begin
				m_q <= mm;
				j_q <= j_q + CITY_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vis_q  <= '0;
			d_q    <= '0;
			best_q <= COST_MAX;
			ocnt_q <= '0;
			for (int k = 0; k < CITIES; k++) begin
				path_q[k]  <= '0;
				cost_q[k]  <= '0;
				bnd_q[k]   <= '0;
				try_q[k]   <= '0;
				bpath_q[k] <= '0;
			end
		end else begin
			if (cmd.init) begin
				best_q    <= COST_MAX;
				vis_q     <= CITIES'(1);
				path_q[0] <= '0;
				cost_q[0] <= '0;
				bnd_q[0]  <= $signed(BND_W'(sum_q >> 1));
				d_q       <= DEPTH_W'(1);
				try_q[1]  <= '0;
				ocnt_q    <= '0;
				for (int k = 0; k < CITIES; k++) bpath_q[k] <= '0;
			end
			if (cmd.step) begin
				try_q[dcur] <= itry + DEPTH_W'(1);
				if (!vis_q[ic]) begin
					vis_q[ic]    <= 1'b1;
					path_q[dcur] <= ic;
				end
			end
			if (cmd.ext) begin
				if (keep) begin
					cost_q[dcur] <= nc;
					bnd_q[dcur]  <= nb;
					d_q          <= dnext;
					if (dnext < DEPTH_W'(CITIES)) try_q[dnext[CITY_W-1:0]] <= '0;
				end else begin
					vis_q[path_q[dcur]] <= 1'b0;
				end
			end
			if (cmd.close && better) begin
				best_q <= nc;
				for (int k = 0; k < CITIES; k++) bpath_q[k] <= path_q[k];
			end
			if (cmd.up) begin
				d_q <= d_q - DEPTH_W'(1);
				if (d_q >= DEPTH_W'(2)) vis_q[prev] <= 1'b0;
			end
			if (cmd.out_adv) ocnt_q <= ocnt_q + CITY_W'(1);
		end
	end

	assign position  = ocnt_q;
	assign city      = bpath_q[ocnt_q];
	assign tour_cost = best_q;
	assign last      = status.out_last;
endmodule

// ----- design/tsp_branch_and_bound.sv -----
// ---------------------------------------------------------------------------
// tsp_branch_and_bound
// Exact shortest closed tour from city 0 by depth-first branch and bound.
// ---------------------------------------------------------------------------
// Input channel (item_valid / item_stall): kind 0 writes distance into the
// matrix entry at row, col; the next request follows at once. kind 1 starts
// a search over the loaded matrix. A search first sweeps the matrix for
// each row's smallest off-diagonal edge, reading each entry and then
// folding it into the row minimum. The search then tries each candidate
// city at each level and extends through unvisited ones, reading each edge
// over the single memory read port; the total depends on the data.
// Output channel (result_valid / result_stall): CITIES results per start,
// one per cycle while not stalled, position 0 first, last on the final one.
// item_stall stays high from the start until the last result is taken.
// A stalled result holds its fields. Reset clears the controller and the
// search state; the distance matrix is undefined until loaded.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tsp_branch_and_bound import tspbb_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	output logic                 item_stall,
	input  logic                 kind,
	input  logic [CITY_W-1:0]    row,
	input  logic [CITY_W-1:0]    col,
	input  logic [DIST_BITS-1:0] distance,
	output logic                 result_valid,
	input  logic                 result_stall,
	output logic [CITY_W-1:0]    position,
	output logic [CITY_W-1:0]    city,
	output logic [COST_W-1:0]    tour_cost,
	output logic                 last
);
	cmd_t    cmd;
	status_t status;

	tspbb_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.kind         (kind),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd),
		.busy         (item_stall),
		.result_valid (result_valid)
	);

	tspbb_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.row       (row),
		.col       (col),
		.distance  (distance),
		.status    (status),
		.position  (position),
		.city      (city),
		.tour_cost (tour_cost),
		.last      (last)
	);
endmodule

// ----- design/tspbb_checker.sv -----
// ---------------------------------------------------------------------------
// tspbb_checker
// Port-level checks on the result sequence of the tour search.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tspbb_checker import tspbb_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              item_stall,
	input logic              result_valid,
	input logic              result_stall,
	input logic [CITY_W-1:0] position,
	input logic [CITY_W-1:0] city,
	input logic [COST_W-1:0] tour_cost,
	input logic              last
);
	a_busy_out: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> item_stall)
		else $error("input taken while results pending");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |-> position == LAST_CITY)
		else $error("last flag on wrong position");

	a_pos_seq: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_stall && !last |=>
			result_valid && position == $past(position) + CITY_W'(1))
		else $error("result positions not consecutive");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=>
			result_valid && $stable(city) && $stable(tour_cost))
		else $error("stalled result changed");
endmodule

bind tsp_branch_and_bound tspbb_checker u_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_stall   (item_stall),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.position     (position),
	.city         (city),
	.tour_cost    (tour_cost),
	.last         (last)
);
